@@ src/fpba_pkg.sv @@
package fpba_pkg;

	// Input operation codes.
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	// Fit policy codes. The unused code behaves as first fit.
	localparam int         POLICY_W   = 2;
	localparam logic [1:0] POL_FIRST  = 2'd0;
	localparam logic [1:0] POL_BEST   = 2'd1;
	localparam logic [1:0] POL_WORST  = 2'd2;

	// Configuration port.
	localparam int         CFG_IDX_W          = 2;
	localparam int         CFG_DATA_W         = 5;
	localparam logic [1:0] REG_FIT_POLICY     = 2'd0;
	localparam logic [1:0] REG_BLOCKS_IN_USE  = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Controls from the sequencer to the datapath.
	typedef struct packed {
		logic idle;     // ready to take a new input item
		logic load_en;  // a load item is written into the cell row this cycle
		logic capture;  // scan result goes to the output register, grant is applied
	} ctl_t;

endpackage

@@ src/fpba_cell.sv @@
module fpba_cell import fpba_pkg::*; #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16,
	parameter int CELL_IDX   = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load_en,
	input  logic [$clog2(NUM_BLOCKS)-1:0]       load_slot,
	input  logic [SIZE_BITS-1:0]                load_bytes,
	input  logic                                grant_en,
	input  logic [$clog2(NUM_BLOCKS)-1:0]       grant_idx,
	input  logic [SIZE_BITS-1:0]                want,
	input  logic [POLICY_W-1:0]                 policy,
	input  logic [CFG_DATA_W-1:0]               blocks_in_use,
	input  logic                                found_in,
	input  logic [$clog2(NUM_BLOCKS)-1:0]       idx_in,
	input  logic [SIZE_BITS-1:0]                size_in,
	output logic                                found_out,
	output logic [$clog2(NUM_BLOCKS)-1:0]       idx_out,
	output logic [SIZE_BITS-1:0]                size_out,
	output logic                                taken
);

	localparam int IDX_W = $clog2(NUM_BLOCKS);
	localparam int CMP_W = (IDX_W + 1 > CFG_DATA_W) ? IDX_W + 1 : CFG_DATA_W;
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [SIZE_BITS-1:0] size_q;
	logic                 taken_q;
	logic                 found_q;
	logic [IDX_W-1:0]     idx_q;
	logic [SIZE_BITS-1:0] cand_size_q;
	logic                 eligible;
	logic                 take;

	always_comb begin
		eligible = !taken_q && (size_q >= want) &&
			(CMP_W'(CELL_IDX) < CMP_W'(blocks_in_use));
		// Strict compares keep the lower index on a tie.
		take = eligible && (!found_in ||
			(policy == POL_BEST  && size_q < size_in) ||
			(policy == POL_WORST && size_q > size_in));
	end

	always_ff @(posedge clk) begin
		if (load_en && load_slot == MY_IDX) begin
			size_q <= load_bytes;
		end
		if (take) begin
			idx_q       <= MY_IDX;
			cand_size_q <= size_q;
		end else begin
			idx_q       <= idx_in;
			cand_size_q <= size_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			if (load_en && load_slot == MY_IDX) begin
				taken_q <= 1'b0;
			end else if (grant_en && grant_idx == MY_IDX) begin
				taken_q <= 1'b1;
			end
			found_q <= found_in || take;
		end
	end

	assign found_out = found_q;
	assign idx_out   = idx_q;
	assign size_out  = cand_size_q;
	assign taken     = taken_q;

endmodule

@@ src/fpba_ctrl.sv @@
module fpba_ctrl import fpba_pkg::*; #(
	parameter int NUM_BLOCKS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_op,
	input  logic out_free,
	output ctl_t ctl
);

	localparam int CNT_W = $clog2(NUM_BLOCKS);

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;

	// The input is never stalled while idle, so a valid request there is an accepted one.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_op == OP_REQUEST) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (cnt_q == CNT_W'(NUM_BLOCKS - 1)) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				ctl.idle    = 1'b1;
				ctl.load_en = in_valid && in_op == OP_LOAD;
			end
			ST_SCAN: ;
			ST_DONE: begin
				ctl.capture = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

endmodule

@@ src/fit_policy_block_allocator_top.sv @@
// Fit-policy block allocator. The block holds NUM_BLOCKS memory blocks, each with a size
// and a taken mark, in a row of cells. A load request (op 0) writes the size of one block,
// frees it and restarts the request count. An allocation request (op 1) is matched against
// every free block among the first blocks_in_use: first fit returns the lowest index that
// fits, best fit the smallest fitting block and worst fit the largest, ties going to the
// lower index. The granted block is marked taken until it is loaded again. A candidate
// travels down the cell row one cell per clock; the controller counts the scan states and
// then, once the output register is free, posts the result and marks the grant. The result
// sits in an output register, so the next request is taken while it waits. Configuration
// (register 0 fit_policy, register 1 blocks_in_use) may only be written while no request is
// in flight; writes are always accepted.
module fit_policy_block_allocator_top import fpba_pkg::*; #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input channel.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [$clog2(NUM_BLOCKS)-1:0] block_slot,
	input  logic [SIZE_BITS-1:0]          block_bytes,
	input  logic [SIZE_BITS-1:0]          request_bytes,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          granted,
	output logic [$clog2(NUM_BLOCKS)-1:0] chosen_block,
	output logic [15:0]                   request_number,
	// Configuration write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);

	localparam int IDX_W = $clog2(NUM_BLOCKS);

	ctl_t ctl;
	logic in_acc;
	logic out_free;

	logic [POLICY_W-1:0]   fit_policy_q;
	logic [CFG_DATA_W-1:0] blocks_in_use_q;
	logic [SIZE_BITS-1:0]  want_q;
	logic [15:0]           req_cnt_q;

	logic                  out_valid_q;
	logic                  granted_q;
	logic [IDX_W-1:0]      chosen_q;
	logic [15:0]           req_num_q;

	// Candidate chain: entry 0 feeds the first cell with "nothing found yet",
	// the last entry is the outcome of the whole scan.
	logic                  chain_found [NUM_BLOCKS+1];
	logic [IDX_W-1:0]      chain_idx   [NUM_BLOCKS+1];
	logic [SIZE_BITS-1:0]  chain_size  [NUM_BLOCKS+1];
	logic [NUM_BLOCKS-1:0] taken_vec;

	logic                  tail_found;
	logic [IDX_W-1:0]      tail_idx;
	logic [SIZE_BITS-1:0]  tail_size;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = !ctl.idle;
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	assign chain_found[0] = 1'b0;
	assign chain_idx[0]   = '0;
	assign chain_size[0]  = '0;

	assign tail_found = chain_found[NUM_BLOCKS];
	assign tail_idx   = chain_idx[NUM_BLOCKS];
	assign tail_size  = chain_size[NUM_BLOCKS];

	fpba_ctrl #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_op   (op),
		.out_free(out_free),
		.ctl     (ctl)
	);

	for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
		fpba_cell #(
			.NUM_BLOCKS(NUM_BLOCKS),
			.SIZE_BITS (SIZE_BITS),
			.CELL_IDX  (g)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.load_en      (ctl.load_en),
			.load_slot    (block_slot),
			.load_bytes   (block_bytes),
			.grant_en     (ctl.capture && tail_found),
			.grant_idx    (tail_idx),
			.want         (want_q),
			.policy       (fit_policy_q),
			.blocks_in_use(blocks_in_use_q),
			.found_in     (chain_found[g]),
			.idx_in       (chain_idx[g]),
			.size_in      (chain_size[g]),
			.found_out    (chain_found[g+1]),
			.idx_out      (chain_idx[g+1]),
			.size_out     (chain_size[g+1]),
			.taken        (taken_vec[g])
		);
	end

	// The requested size is held for the whole scan.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			want_q <= request_bytes;
		end
		if (ctl.capture) begin
			granted_q <= tail_found;
			chosen_q  <= tail_found ? tail_idx : '0;
			req_num_q <= req_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q    <= POL_FIRST;
			blocks_in_use_q <= CFG_DATA_W'(16);
			req_cnt_q       <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FIT_POLICY:    fit_policy_q    <= cfg_data[POLICY_W-1:0];
					REG_BLOCKS_IN_USE: blocks_in_use_q <= cfg_data;
					default: ;
				endcase
			end
			// A load restarts the count; every request, granted or refused, takes a number.
			if (ctl.load_en) begin
				req_cnt_q <= '0;
			end else if (ctl.capture) begin
				req_cnt_q <= req_cnt_q + 16'd1;
			end
			if (ctl.capture) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign granted        = granted_q;
	assign chosen_block   = chosen_q;
	assign request_number = req_num_q;

	// A grant never picks a block that is already taken.
	a_grant_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.capture && tail_found |-> !taken_vec[tail_idx])
		else $error("grant of a taken block");

	// The granted block is marked taken right after the grant.
	a_grant_marks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.capture && tail_found |=> taken_vec[$past(tail_idx)])
		else $error("granted block not marked taken");

	// A granted block is large enough for the request.
	a_grant_fits: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.capture && tail_found |-> tail_size >= want_q)
		else $error("granted block smaller than the request");

	// A result is only posted into a free output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.capture |-> !out_valid_q || !out_stall)
		else $error("result overwritten before it was taken");

endmodule
